[rtl/uart_tx_rx_ring_buffers_top_macros.svh]
// assertion macros used by the port level checker file
`ifndef UART_TX_RX_RING_BUFFERS_TOP_MACROS_SVH
`define UART_TX_RX_RING_BUFFERS_TOP_MACROS_SVH

// clocked assertion, switched off while reset is high
`define UTRB_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("utrb assertion failed");

// clocked assertion that also holds across reset
`define UTRB_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("utrb assertion failed");

`endif

[rtl/utrb_pkg.sv]
// shared types and constants for the serial port ring buffers
package utrb_pkg;

   localparam int TX_DEPTH_DEF = 16;
   localparam int RX_DEPTH_DEF = 16;
   localparam int FILL_W       = 5;

   typedef enum logic [2:0] {
      OP_RX_BYTE    = 3'd0,
      OP_TX_READY   = 3'd1,
      OP_HOST_READ  = 3'd2,
      OP_HOST_SEND  = 3'd3,
      OP_SPACE_CHK  = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_NO_ROOM = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      BYTE_NONE = 2'd0,
      BYTE_TX   = 2'd1,
      BYTE_RX   = 2'd2
   } byte_sel_type;

   typedef struct packed {
      byte_sel_type        byte_sel;
      status_type          status;
      logic                line_byte_valid;
      logic                tx_irq_enable;
      logic [FILL_W-1:0]   rx_fill;
      logic [FILL_W-1:0]   tx_fill;
   } stage_type;

   typedef struct packed {
      logic [7:0]          out_byte;
      status_type          status;
      logic                line_byte_valid;
      logic                tx_irq_enable;
      logic [FILL_W-1:0]   rx_fill;
      logic [FILL_W-1:0]   tx_fill;
   } rsp_payload_type;

endpackage

[rtl/utrb_if.sv]
// request and response channel interfaces
interface utrb_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] opcode;
   logic [7:0] data_byte;
   logic [7:0] request_length;

   modport source (output valid, output opcode, output data_byte, output request_length,
                   input ready);
   modport sink (input valid, input opcode, input data_byte, input request_length,
                 output ready);
endinterface

interface utrb_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [7:0]                      out_byte;
   logic [1:0]                      status;
   logic                            line_byte_valid;
   logic                            tx_irq_enable;
   logic [utrb_pkg::FILL_W-1:0]     rx_fill;
   logic [utrb_pkg::FILL_W-1:0]     tx_fill;

   modport source (output valid, output out_byte, output status, output line_byte_valid,
                   output tx_irq_enable, output rx_fill, output tx_fill, input ready);
   modport sink (input valid, input out_byte, input status, input line_byte_valid,
                 input tx_irq_enable, input rx_fill, input tx_fill, output ready);
endinterface

[rtl/utrb_ram.sv]
// byte ring storage, one write and one registered read port
module utrb_ram #(
   parameter int DEPTH = utrb_pkg::TX_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [7:0]               wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [7:0]               rd_data_ff
);

   logic [7:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

[rtl/utrb_ctrl.sv]
// ring pointers, counts, interrupt enable and the first result stage
module utrb_ctrl #(
   parameter int TX_DEPTH = utrb_pkg::TX_DEPTH_DEF,
   parameter int RX_DEPTH = utrb_pkg::RX_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   utrb_req_if.sink            req_chan,
   input  logic                s1_take,
   output logic                s1_valid_ff,
   output utrb_pkg::stage_type s1_ff,
   output logic [7:0]          s1_byte
);

   localparam int TAW = $clog2(TX_DEPTH);
   localparam int TCW = $clog2(TX_DEPTH + 1);
   localparam int RAW = $clog2(RX_DEPTH);
   localparam int RCW = $clog2(RX_DEPTH + 1);
   localparam int SW  = ((TCW > 8) ? TCW : 8) + 1;
   localparam int FW  = utrb_pkg::FILL_W;

   logic [TAW-1:0] tx_rp_ff, tx_rp_in;
   logic [TCW-1:0] tx_cnt_ff, tx_cnt_in;
   logic [RAW-1:0] rx_wp_ff, rx_wp_in;
   logic [RCW-1:0] rx_cnt_ff, rx_cnt_in;
   logic           irq_en_ff, irq_en_in;
   logic           s1_valid_in;
   utrb_pkg::stage_type s1_in;

   logic           accept;
   utrb_pkg::opcode_type op;
   logic [TAW:0]   tx_rp_inc;
   logic [TAW-1:0] tx_rp_next;
   logic [TCW:0]   tx_widx_sum;
   logic [TCW:0]   tx_widx;
   logic [RAW:0]   rx_wp_inc;
   logic [RAW-1:0] rx_wp_next;
   logic [RCW:0]   rx_ridx;
   logic [SW-1:0]  space_sum;
   logic [RCW+FW-1:0] rx_fill_ext;
   logic [TCW+FW-1:0] tx_fill_ext;

   logic           tx_we, tx_re, rx_we, rx_re;
   logic [7:0]     tx_rdata, rx_rdata;

   assign req_chan.ready = !s1_valid_ff || s1_take;
   assign accept         = req_chan.valid && req_chan.ready;
   assign op             = utrb_pkg::opcode_type'(req_chan.opcode);

   // pointer arithmetic
   always_comb begin
      tx_rp_inc   = (TAW + 1)'(tx_rp_ff) + (TAW + 1)'(1);
      tx_rp_next  = (tx_rp_inc >= (TAW + 1)'(TX_DEPTH)) ? '0 : tx_rp_inc[TAW-1:0];
      tx_widx_sum = (TCW + 1)'(tx_rp_ff) + (TCW + 1)'(tx_cnt_ff);
      tx_widx     = (tx_widx_sum >= (TCW + 1)'(TX_DEPTH))
                    ? tx_widx_sum - (TCW + 1)'(TX_DEPTH) : tx_widx_sum;
      rx_wp_inc   = (RAW + 1)'(rx_wp_ff) + (RAW + 1)'(1);
      rx_wp_next  = (rx_wp_inc >= (RAW + 1)'(RX_DEPTH)) ? '0 : rx_wp_inc[RAW-1:0];
      rx_ridx     = ((RCW + 1)'(rx_wp_ff) >= (RCW + 1)'(rx_cnt_ff))
                    ? (RCW + 1)'(rx_wp_ff) - (RCW + 1)'(rx_cnt_ff)
                    : (RCW + 1)'(rx_wp_ff) + (RCW + 1)'(RX_DEPTH) - (RCW + 1)'(rx_cnt_ff);
      space_sum   = SW'(req_chan.request_length) + SW'(tx_cnt_ff);
   end

   // per transaction state update
   always_comb begin
      tx_rp_in  = tx_rp_ff;
      tx_cnt_in = tx_cnt_ff;
      rx_wp_in  = rx_wp_ff;
      rx_cnt_in = rx_cnt_ff;
      irq_en_in = irq_en_ff;
      tx_we     = 1'b0;
      tx_re     = 1'b0;
      rx_we     = 1'b0;
      rx_re     = 1'b0;
      s1_in     = '0;
      s1_in.byte_sel = utrb_pkg::BYTE_NONE;
      s1_in.status   = utrb_pkg::ST_OK;
      case (op)
         utrb_pkg::OP_RX_BYTE: begin
            rx_we    = 1'b1;
            rx_wp_in = rx_wp_next;
            if (rx_cnt_ff < RCW'(RX_DEPTH)) begin
               rx_cnt_in = rx_cnt_ff + RCW'(1);
            end
         end
         utrb_pkg::OP_TX_READY: begin
            if (tx_cnt_ff != '0) begin
               tx_re                 = 1'b1;
               tx_rp_in              = tx_rp_next;
               tx_cnt_in             = tx_cnt_ff - TCW'(1);
               s1_in.byte_sel        = utrb_pkg::BYTE_TX;
               s1_in.line_byte_valid = 1'b1;
            end else begin
               irq_en_in    = 1'b0;
               s1_in.status = utrb_pkg::ST_EMPTY;
            end
         end
         utrb_pkg::OP_HOST_READ: begin
            if (rx_cnt_ff != '0) begin
               rx_re          = 1'b1;
               rx_cnt_in      = rx_cnt_ff - RCW'(1);
               s1_in.byte_sel = utrb_pkg::BYTE_RX;
            end else begin
               s1_in.status = utrb_pkg::ST_EMPTY;
            end
         end
         utrb_pkg::OP_HOST_SEND: begin
            if (tx_cnt_ff < TCW'(TX_DEPTH)) begin
               tx_we     = 1'b1;
               tx_cnt_in = tx_cnt_ff + TCW'(1);
            end else begin
               s1_in.status = utrb_pkg::ST_NO_ROOM;
            end
            irq_en_in = 1'b1;
         end
         utrb_pkg::OP_SPACE_CHK: begin
            if (space_sum >= SW'(TX_DEPTH)) begin
               s1_in.status = utrb_pkg::ST_NO_ROOM;
            end
         end
         default: begin
         end
      endcase
      rx_fill_ext         = (RCW + FW)'(rx_cnt_in);
      tx_fill_ext         = (TCW + FW)'(tx_cnt_in);
      s1_in.rx_fill       = rx_fill_ext[FW-1:0];
      s1_in.tx_fill       = tx_fill_ext[FW-1:0];
      s1_in.tx_irq_enable = irq_en_in;
      s1_valid_in = accept ? 1'b1 : (s1_take ? 1'b0 : s1_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_rp_ff    <= '0;
         tx_cnt_ff   <= '0;
         rx_wp_ff    <= '0;
         rx_cnt_ff   <= '0;
         irq_en_ff   <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (accept) begin
            tx_rp_ff  <= tx_rp_in;
            tx_cnt_ff <= tx_cnt_in;
            rx_wp_ff  <= rx_wp_in;
            rx_cnt_ff <= rx_cnt_in;
            irq_en_ff <= irq_en_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
   end

   utrb_ram #(.DEPTH(TX_DEPTH)) u_tx_ram (
      .clock      (clock),
      .wr_en      (accept && tx_we),
      .wr_addr    (tx_widx[TAW-1:0]),
      .wr_data    (req_chan.data_byte),
      .rd_en      (accept && tx_re),
      .rd_addr    (tx_rp_ff),
      .rd_data_ff (tx_rdata)
   );

   utrb_ram #(.DEPTH(RX_DEPTH)) u_rx_ram (
      .clock      (clock),
      .wr_en      (accept && rx_we),
      .wr_addr    (rx_wp_ff),
      .wr_data    (req_chan.data_byte),
      .rd_en      (accept && rx_re),
      .rd_addr    (rx_ridx[RAW-1:0]),
      .rd_data_ff (rx_rdata)
   );

   always_comb begin
      case (s1_ff.byte_sel)
         utrb_pkg::BYTE_TX: s1_byte = tx_rdata;
         utrb_pkg::BYTE_RX: s1_byte = rx_rdata;
         default:           s1_byte = 8'd0;
      endcase
   end

endmodule

[rtl/uart_tx_rx_ring_buffers_top.sv]
// top level of the serial port transmit and receive ring buffers
//
//   channel   dir   handshake          payload
//   req_chan  in    valid / ready      opcode, data_byte, request_length
//   rsp_chan  out   valid / ready      out_byte, status, line_byte_valid,
//                                      tx_irq_enable, rx_fill, tx_fill
//
// one transaction per cycle sustained while the response side is ready
// a response is registered with the ring storage read, then in the response register
// reset is synchronous, clears pointers, counts and the enable; storage is not cleared
// a stalled response holds its register while one more request is still taken
module uart_tx_rx_ring_buffers_top #(
   parameter int TX_DEPTH = utrb_pkg::TX_DEPTH_DEF,
   parameter int RX_DEPTH = utrb_pkg::RX_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   utrb_req_if.sink   req_chan,
   utrb_rsp_if.source rsp_chan
);

   logic                      s1_valid;
   utrb_pkg::stage_type       s1;
   logic [7:0]                s1_byte;
   logic                      s1_take;
   logic                      rsp_valid_ff, rsp_valid_in;
   utrb_pkg::rsp_payload_type rsp_ff;
   logic                      out_free;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign s1_take  = s1_valid && out_free;

   utrb_ctrl #(.TX_DEPTH(TX_DEPTH), .RX_DEPTH(RX_DEPTH)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .s1_take     (s1_take),
      .s1_valid_ff (s1_valid),
      .s1_ff       (s1),
      .s1_byte     (s1_byte)
   );

   assign rsp_valid_in = s1_take ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_take) begin
         rsp_ff.out_byte        <= s1_byte;
         rsp_ff.status          <= s1.status;
         rsp_ff.line_byte_valid <= s1.line_byte_valid;
         rsp_ff.tx_irq_enable   <= s1.tx_irq_enable;
         rsp_ff.rx_fill         <= s1.rx_fill;
         rsp_ff.tx_fill         <= s1.tx_fill;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.out_byte        = rsp_ff.out_byte;
   assign rsp_chan.status          = rsp_ff.status;
   assign rsp_chan.line_byte_valid = rsp_ff.line_byte_valid;
   assign rsp_chan.tx_irq_enable   = rsp_ff.tx_irq_enable;
   assign rsp_chan.rx_fill         = rsp_ff.rx_fill;
   assign rsp_chan.tx_fill         = rsp_ff.tx_fill;

endmodule

[rtl/utrb_checker.sv]
// port level checks for the ring buffer top, bound to every instance
`include "uart_tx_rx_ring_buffers_top_macros.svh"

module utrb_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [7:0]                  rsp_out_byte,
   input logic [1:0]                  rsp_status,
   input logic                        rsp_line_byte_valid,
   input logic                        rsp_tx_irq_enable
);

   // a stalled response keeps its byte and its status
   `UTRB_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_status))

   // nothing is offered straight after reset
   `UTRB_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid)

   // a byte handed to the line always comes with an ok status
   `UTRB_ASSERT(a_line_ok, clock, reset, rsp_valid && rsp_line_byte_valid |-> rsp_status == utrb_pkg::ST_OK)

   // bytes in the transmit ring imply the interrupt enable is still set
   `UTRB_ASSERT(a_line_irq, clock, reset, rsp_valid && rsp_line_byte_valid |-> rsp_tx_irq_enable)

endmodule

bind uart_tx_rx_ring_buffers_top utrb_checker u_utrb_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .rsp_out_byte        (rsp_chan.out_byte),
   .rsp_status          (rsp_chan.status),
   .rsp_line_byte_valid (rsp_chan.line_byte_valid),
   .rsp_tx_irq_enable   (rsp_chan.tx_irq_enable)
);

[verif/uart_tx_rx_ring_buffers_checker.sv]
`timescale 1ns / 1ps
// response predictor and scoreboard for the serial port ring buffers
module uart_tx_rx_ring_buffers_checker (
   input  logic clock,
   input  logic reset,
   utrb_req_if  req_chan,
   utrb_rsp_if  rsp_chan,
   output int   error_count,
   output int   outstanding,
   output int   checked_count,
   output int   rx_overrun_count,
   output int   tx_refused_count
);

   localparam int TX_DEPTH = utrb_pkg::TX_DEPTH_DEF;
   localparam int RX_DEPTH = utrb_pkg::RX_DEPTH_DEF;
   localparam int FW       = utrb_pkg::FILL_W;

   logic [7:0]                tx_ring [TX_DEPTH];
   logic [7:0]                rx_ring [RX_DEPTH];
   int                        tx_rd_ptr;
   int                        tx_level;
   int                        rx_wr_ptr;
   int                        rx_level;
   logic                      irq_en;
   utrb_pkg::rsp_payload_type awaited_rsp_q [$];

   function automatic utrb_pkg::rsp_payload_type ring_step(input logic [2:0] op,
                                                           input logic [7:0] data,
                                                           input logic [7:0] len);
      utrb_pkg::rsp_payload_type r;
      int                        idx;
      r = '0;
      case (op)
         utrb_pkg::OP_RX_BYTE: begin
            rx_ring[rx_wr_ptr] = data;
            rx_wr_ptr = (rx_wr_ptr + 1) % RX_DEPTH;
            if (rx_level < RX_DEPTH) begin
               rx_level++;
            end else begin
               rx_overrun_count++;
            end
         end
         utrb_pkg::OP_TX_READY: begin
            if (tx_level > 0) begin
               r.out_byte = tx_ring[tx_rd_ptr];
               r.line_byte_valid = 1'b1;
               tx_rd_ptr = (tx_rd_ptr + 1) % TX_DEPTH;
               tx_level--;
            end else begin
               irq_en = 1'b0;
               r.status = utrb_pkg::ST_EMPTY;
            end
         end
         utrb_pkg::OP_HOST_READ: begin
            if (rx_level > 0) begin
               idx = (rx_wr_ptr - rx_level + RX_DEPTH) % RX_DEPTH;
               r.out_byte = rx_ring[idx];
               rx_level--;
            end else begin
               r.status = utrb_pkg::ST_EMPTY;
            end
         end
         utrb_pkg::OP_HOST_SEND: begin
            if (tx_level < TX_DEPTH) begin
               tx_ring[(tx_rd_ptr + tx_level) % TX_DEPTH] = data;
               tx_level++;
            end else begin
               r.status = utrb_pkg::ST_NO_ROOM;
               tx_refused_count++;
            end
            irq_en = 1'b1;
         end
         utrb_pkg::OP_SPACE_CHK: begin
            if (int'(len) + tx_level >= TX_DEPTH) begin
               r.status = utrb_pkg::ST_NO_ROOM;
            end
         end
         default: begin
         end
      endcase
      r.tx_irq_enable = irq_en;
      r.rx_fill = FW'(rx_level);
      r.tx_fill = FW'(tx_level);
      return r;
   endfunction

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      utrb_pkg::rsp_payload_type want;
      if (reset) begin
         tx_rd_ptr = 0;
         tx_level = 0;
         rx_wr_ptr = 0;
         rx_level = 0;
         irq_en = 1'b0;
         awaited_rsp_q.delete();
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (awaited_rsp_q.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual byte %0d status %0d",
                        $time, rsp_chan.out_byte, rsp_chan.status);
               error_count++;
            end else begin
               want = awaited_rsp_q.pop_front();
               check_field("out_byte", want.out_byte, rsp_chan.out_byte);
               check_field("status", 8'(want.status), 8'(rsp_chan.status));
               check_field("line_byte_valid", 8'(want.line_byte_valid),
                           8'(rsp_chan.line_byte_valid));
               check_field("tx_irq_enable", 8'(want.tx_irq_enable), 8'(rsp_chan.tx_irq_enable));
               check_field("rx_fill", 8'(want.rx_fill), 8'(rsp_chan.rx_fill));
               check_field("tx_fill", 8'(want.tx_fill), 8'(rsp_chan.tx_fill));
               checked_count++;
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            awaited_rsp_q.push_back(ring_step(req_chan.opcode, req_chan.data_byte,
                                              req_chan.request_length));
         end
      end
      outstanding = awaited_rsp_q.size();
   end

endmodule

[verif/uart_tx_rx_ring_buffers_top_test.sv]
`timescale 1ns / 1ps
// stimulus, clocking and verdict for the serial port ring buffer testbench
module uart_tx_rx_ring_buffers_top_test;

   localparam int         HALF_PERIOD  = 10;
   localparam int         RESET_CYCLES = 7;
   localparam int         ITEM_TARGET  = 550;
   localparam int         IDLE_LIMIT   = 2000;
   localparam int         LONG_HOLD    = 90;
   localparam int         DRAIN_CYCLES = 10;
   localparam logic [2:0] OP_SPARE_LO  = 3'd5;
   localparam logic [2:0] OP_SPARE_MID = 3'd6;
   localparam logic [2:0] OP_SPARE_HI  = 3'd7;

   typedef enum {DRAIN_EAGER, DRAIN_PATCHY, DRAIN_SLUGGISH} drain_mode_type;
   typedef enum {SCN_RX_FLOOD, SCN_TX_FLOOD, SCN_MIXED, SCN_NOISE} scenario_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   items_sent  = 0;
   int   burst_left  = 0;
   int   cycle_count = 0;
   int   idle_cycles = 0;
   int   error_count;
   int   outstanding;
   int   checked_count;
   int   rx_overrun_count;
   int   tx_refused_count;

   utrb_req_if req_chan();
   utrb_rsp_if rsp_chan();

   uart_tx_rx_ring_buffers_top u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   uart_tx_rx_ring_buffers_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .error_count      (error_count),
      .outstanding      (outstanding),
      .checked_count    (checked_count),
      .rx_overrun_count (rx_overrun_count),
      .tx_refused_count (tx_refused_count)
   );

   always #HALF_PERIOD clock = ~clock;

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: watchdog, no transaction for %0d cycles", $time, IDLE_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // response side stalls on its own pattern, with long hold-offs to fill the block
   initial begin
      drain_mode_type mode;
      int             hold;
      mode = DRAIN_EAGER;
      hold = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (cycle_count == 400 || cycle_count == 1100) begin
            hold = LONG_HOLD;
         end
         if (cycle_count % 64 == 0) begin
            mode = drain_mode_type'($urandom_range(0, 2));
         end
         if (hold > 0) begin
            hold--;
            rsp_chan.ready <= 1'b0;
         end else begin
            case (mode)
               DRAIN_EAGER:  rsp_chan.ready <= 1'b1;
               DRAIN_PATCHY: rsp_chan.ready <= 1'($urandom_range(0, 1));
               default:      rsp_chan.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   function automatic logic [7:0] pick_len();
      if ($urandom_range(0, 3) == 0) begin
         return 8'($urandom);
      end
      return 8'($urandom_range(0, 20));
   endfunction

   task automatic send_item(input logic [2:0] op, input logic [7:0] data, input logic [7:0] len);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 8);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_chan.valid          <= 1'b1;
      req_chan.opcode         <= op;
      req_chan.data_byte      <= data;
      req_chan.request_length <= len;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      items_sent++;
   endtask

   initial begin
      int n;
      req_chan.valid          <= 1'b0;
      req_chan.opcode         <= utrb_pkg::OP_RX_BYTE;
      req_chan.data_byte      <= 8'h00;
      req_chan.request_length <= 8'h00;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // empty rings, space check edges, both byte extremes, spare opcodes
      send_item(utrb_pkg::OP_HOST_READ, 8'h00, 8'h00);
      send_item(utrb_pkg::OP_TX_READY, 8'h00, 8'h00);
      send_item(utrb_pkg::OP_SPACE_CHK, 8'h00, 8'd0);
      send_item(utrb_pkg::OP_SPACE_CHK, 8'h00, 8'd15);
      send_item(utrb_pkg::OP_SPACE_CHK, 8'h00, 8'd16);
      send_item(utrb_pkg::OP_SPACE_CHK, 8'hFF, 8'd255);
      send_item(utrb_pkg::OP_HOST_SEND, 8'h00, 8'h00);
      send_item(utrb_pkg::OP_HOST_SEND, 8'hFF, 8'hFF);
      send_item(utrb_pkg::OP_SPACE_CHK, 8'h00, 8'd14);
      send_item(utrb_pkg::OP_SPACE_CHK, 8'h00, 8'd13);
      send_item(utrb_pkg::OP_TX_READY, 8'h00, 8'h00);
      send_item(utrb_pkg::OP_TX_READY, 8'h00, 8'h00);
      send_item(utrb_pkg::OP_TX_READY, 8'h00, 8'h00);
      send_item(utrb_pkg::OP_RX_BYTE, 8'hFF, 8'h00);
      send_item(utrb_pkg::OP_RX_BYTE, 8'h00, 8'hFF);
      send_item(utrb_pkg::OP_RX_BYTE, 8'hA5, 8'h5A);
      repeat (4) send_item(utrb_pkg::OP_HOST_READ, 8'h00, 8'h00);
      send_item(OP_SPARE_LO, 8'hFF, 8'hFF);
      send_item(OP_SPARE_MID, 8'h00, 8'h00);
      send_item(OP_SPARE_HI, 8'h5A, 8'hA5);

      while (items_sent < ITEM_TARGET) begin
         case (scenario_type'($urandom_range(0, 3)))
            SCN_RX_FLOOD: begin
               n = $urandom_range(10, 20);
               repeat (n) send_item(utrb_pkg::OP_RX_BYTE, 8'($urandom), 8'($urandom));
               n = $urandom_range(0, 20);
               repeat (n) send_item(utrb_pkg::OP_HOST_READ, 8'($urandom), 8'($urandom));
            end
            SCN_TX_FLOOD: begin
               n = $urandom_range(10, 20);
               repeat (n) begin
                  if ($urandom_range(0, 3) == 0) begin
                     send_item(utrb_pkg::OP_SPACE_CHK, 8'($urandom), pick_len());
                  end
                  send_item(utrb_pkg::OP_HOST_SEND, 8'($urandom), 8'($urandom));
               end
               send_item(utrb_pkg::OP_SPACE_CHK, 8'($urandom), pick_len());
               n = $urandom_range(0, 20);
               repeat (n) send_item(utrb_pkg::OP_TX_READY, 8'($urandom), 8'($urandom));
            end
            SCN_MIXED: begin
               repeat (12) send_item(3'($urandom_range(0, 4)), 8'($urandom), pick_len());
            end
            default: begin
               repeat (6) send_item(3'($urandom), 8'($urandom), 8'($urandom));
            end
         endcase
      end

      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests over every opcode and the spare codes, %0d responses checked",
               items_sent, checked_count);
      $display("receive ring overruns %0d, refused host sends %0d, with receiver hold-offs",
               rx_overrun_count, tx_refused_count);
      if (error_count == 0 && outstanding == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
